// ----- design/clock_page_replacement_assert.svh -----
// ----------------------------------------------------------------------------
// Clock page replacement assertion macros
// Shared property forms used by the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CLOCK_PAGE_REPLACEMENT_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication
`define CRP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/crp_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock page replacement package
// Shared widths, register codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package crp_pkg;

   localparam int PAGE_BITS      = 16;
   localparam int IDX_OUT_BITS   = 4;
   localparam int FAULT_BITS     = 16;
   localparam int FIU_BITS       = 5;
   localparam int REQ_TDATA_BITS = 16;
   localparam int RSP_TDATA_BITS = 40;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [FIU_BITS-1:0]   FIU_RESET = 5'd16;
   localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;

   // register index, taken from paddr[2]
   localparam logic REG_FRAMES_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SWEEP,
      ST_EVICT,
      ST_OUT
   } crp_state_type;

   typedef struct packed {
      logic req_valid;
      logic lk_hit;
      logic lk_miss;
      logic ref_set;
      logic rsp_free;
   } crp_stat_type;

   typedef struct packed {
      logic req_ready;
      logic lookup;
      logic do_hit;
      logic sweep_clear;
      logic do_evict;
      logic load_rsp;
   } crp_ctrl_type;

endpackage

// ----- design/crp_page_ram.sv -----
// ----------------------------------------------------------------------------
// Page store
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module crp_page_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/crp_unit.sv -----
// ----------------------------------------------------------------------------
// Clock page replacement step unit
// Page compare and wrapping frame increment, shared by lookup, sweep and update.
// ----------------------------------------------------------------------------
module crp_unit
   import crp_pkg::*;
#(
   parameter int HW = 4
) (
   input  logic [HW-1:0]        idx,
   input  logic [HW-1:0]        last_idx,
   input  logic [PAGE_BITS-1:0] page_a,
   input  logic [PAGE_BITS-1:0] page_b,
   output logic                 eq,
   output logic                 at_last,
   output logic [HW-1:0]        nxt
);

   always_comb begin
      eq      = (page_a == page_b);
      at_last = (idx == last_idx);
      nxt     = at_last ? '0 : HW'(idx + 1'b1);
   end

endmodule

// ----- design/crp_seq.sv -----
// ----------------------------------------------------------------------------
// Clock page replacement sequencer
// Steps one transaction through lookup, sweep, eviction and result hand-off.
// ----------------------------------------------------------------------------
module crp_seq
   import crp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  crp_stat_type stat,
   output crp_ctrl_type ctrl,
   output crp_state_type state
);

   crp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (stat.req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (stat.lk_hit) state_in = ST_OUT;
            else if (stat.lk_miss) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            if (!stat.ref_set) state_in = ST_EVICT;
         end
         ST_EVICT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.req_ready = 1'b1;
         end
         ST_LOOKUP: begin
            ctrl.lookup = 1'b1;
            ctrl.do_hit = stat.lk_hit;
         end
         ST_SWEEP: begin
            ctrl.sweep_clear = stat.ref_set;
         end
         ST_EVICT: begin
            ctrl.do_evict = 1'b1;
         end
         ST_OUT: begin
            ctrl.load_rsp = stat.rsp_free;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ----- design/clock_page_replacement.sv -----
// ----------------------------------------------------------------------------
// Clock page replacement
// Second-chance frame allocator with saturating fault count.
// ----------------------------------------------------------------------------
// Each req transaction carries one page reference (tlast marks the final one
// of a sequence and is echoed on rsp). The block answers with one rsp
// transaction: hit flag in tuser, and frame, eviction and fault total in tdata.
// One transaction is in work at a time; req_tready is high only when idle.
// Lookup walks the page store one frame per cycle through its registered read
// port. A hit goes from lookup straight to the output state; a miss goes on
// through the sweep, which clears set reference bits and advances the hand
// until it meets a clear one, then through eviction and output.
// The result waits in the rsp register while rsp_tready is low; the block is
// idle again once the result has moved into that register.
// Reset empties all frames, clears reference bits, hand and fault count, and
// sets frames_in_use to 16. The user writes frames_in_use over csr byte address
// 0, only while no transaction is in work; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "clock_page_replacement_assert.svh"

module clock_page_replacement
   import crp_pkg::*;
#(
   parameter int MAX_FRAMES = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // [15:0] page
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [3:0] frame_index, [4] evicted_valid, [20:5] evicted_page,
   // [36:21] fault_total, [39:37] zero
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   output logic                      rsp_tuser,   // [0] hit
   output logic                      rsp_tlast,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                      csr_pready
);

   localparam int HW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW   = $clog2(MAX_FRAMES + 1);
   localparam int CMPW = (CW > FIU_BITS) ? CW : FIU_BITS;

   crp_stat_type  stat;
   crp_ctrl_type  ctrl;
   crp_state_type state;

   logic [FIU_BITS-1:0]   fiu_ff, fiu_in;
   logic [PAGE_BITS-1:0]  page_ff, page_in;
   logic                  last_ff, last_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  cmp_pend_ff, cmp_pend_in;
   logic [HW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [HW-1:0]         hand_ff, hand_in;
   logic [MAX_FRAMES-1:0] valid_ff, valid_in;
   logic [MAX_FRAMES-1:0] ref_ff, ref_in;
   logic [FAULT_BITS-1:0] fault_ff, fault_in;

   logic                  res_hit_ff, res_hit_in;
   logic [HW-1:0]         res_slot_ff, res_slot_in;
   logic                  res_evv_ff, res_evv_in;
   logic [PAGE_BITS-1:0]  res_evp_ff, res_evp_in;
   logic [FAULT_BITS-1:0] res_fault_ff, res_fault_in;

   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                      rsp_tuser_ff, rsp_tuser_in;
   logic                      rsp_tlast_ff, rsp_tlast_in;

   logic [CW-1:0]         count;
   logic [HW-1:0]         last_idx;
   logic [CMPW-1:0]       fiu_ext;
   logic                  req_fire;
   logic                  csr_wr;
   logic                  issue_ok;
   logic [HW-1:0]         unit_idx;
   logic                  unit_eq;
   logic                  unit_at_last;
   logic [HW-1:0]         unit_nxt;
   logic [HW-1:0]         ram_raddr;
   logic [PAGE_BITS-1:0]  ram_rdata;
   logic [FAULT_BITS-1:0] fault_inc;

   // active frame count, clamped to 1..MAX_FRAMES
   always_comb begin
      fiu_ext = CMPW'(fiu_ff);
      if (fiu_ff == '0) begin
         count = CW'(1);
      end else if (fiu_ext > CMPW'(MAX_FRAMES)) begin
         count = CW'(MAX_FRAMES);
      end else begin
         count = CW'(fiu_ff);
      end
      last_idx = HW'(count - 1'b1);
   end

   assign unit_idx  = cmp_pend_ff ? cmp_idx_ff : hand_ff;
   assign ram_raddr = ctrl.lookup ? scan_ff[HW-1:0] : hand_ff;

   crp_unit #(
      .HW (HW)
   ) u_unit (
      .idx      (unit_idx),
      .last_idx (last_idx),
      .page_a   (ram_rdata),
      .page_b   (page_ff),
      .eq       (unit_eq),
      .at_last  (unit_at_last),
      .nxt      (unit_nxt)
   );

   crp_page_ram #(
      .DEPTH (MAX_FRAMES),
      .AW    (HW),
      .DW    (PAGE_BITS)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ctrl.do_evict),
      .wr_addr (hand_ff),
      .wr_data (page_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      stat.req_valid = req_tvalid;
      stat.lk_hit    = cmp_pend_ff && valid_ff[cmp_idx_ff] && unit_eq;
      stat.lk_miss   = cmp_pend_ff && !stat.lk_hit && unit_at_last;
      stat.ref_set   = ref_ff[hand_ff];
      stat.rsp_free  = !rsp_tvalid_ff || rsp_tready;
   end

   crp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl),
      .state (state)
   );

   assign req_tready = ctrl.req_ready;
   assign req_fire   = req_tvalid && ctrl.req_ready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign issue_ok   = (scan_ff != count);
   assign fault_inc  = (fault_ff == FAULT_MAX) ? fault_ff : fault_ff + 1'b1;

   always_comb begin
      fiu_in       = fiu_ff;
      page_in      = page_ff;
      last_in      = last_ff;
      scan_in      = scan_ff;
      cmp_pend_in  = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hand_in      = hand_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      fault_in     = fault_ff;
      res_hit_in   = res_hit_ff;
      res_slot_in  = res_slot_ff;
      res_evv_in   = res_evv_ff;
      res_evp_in   = res_evp_ff;
      res_fault_in = res_fault_ff;

      if (csr_wr && csr_paddr[2] == REG_FRAMES_IN_USE) begin
         fiu_in = csr_pwdata[FIU_BITS-1:0];
      end

      if (req_fire) begin
         page_in = req_tdata[PAGE_BITS-1:0];
         last_in = req_tlast;
         scan_in = '0;
         if (CW'(hand_ff) >= count) begin
            hand_in = '0;
         end
      end

      if (ctrl.lookup && issue_ok) begin
         scan_in     = CW'(scan_ff + 1'b1);
         cmp_idx_in  = scan_ff[HW-1:0];
         cmp_pend_in = !(stat.lk_hit || stat.lk_miss);
      end

      if (ctrl.do_hit) begin
         ref_in[cmp_idx_ff] = 1'b1;
         hand_in            = unit_nxt;
         res_hit_in         = 1'b1;
         res_slot_in        = cmp_idx_ff;
         res_evv_in         = 1'b0;
         res_evp_in         = '0;
         res_fault_in       = fault_ff;
      end

      if (ctrl.sweep_clear) begin
         ref_in[hand_ff] = 1'b0;
         hand_in         = unit_nxt;
      end

      if (ctrl.do_evict) begin
         valid_in[hand_ff] = 1'b1;
         ref_in[hand_ff]   = 1'b1;
         hand_in           = unit_nxt;
         fault_in          = fault_inc;
         res_hit_in        = 1'b0;
         res_slot_in       = hand_ff;
         res_evv_in        = valid_ff[hand_ff];
         res_evp_in        = valid_ff[hand_ff] ? ram_rdata : '0;
         res_fault_in      = fault_inc;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (ctrl.load_rsp) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {3'b000, res_fault_ff, res_evp_ff, res_evv_ff,
                          IDX_OUT_BITS'(res_slot_ff)};
         rsp_tuser_in  = res_hit_ff;
         rsp_tlast_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff        <= FIU_RESET;
         cmp_pend_ff   <= 1'b0;
         hand_ff       <= '0;
         valid_ff      <= '0;
         ref_ff        <= '0;
         fault_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         fiu_ff        <= fiu_in;
         cmp_pend_ff   <= cmp_pend_in;
         hand_ff       <= hand_in;
         valid_ff      <= valid_in;
         ref_ff        <= ref_in;
         fault_ff      <= fault_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      last_ff      <= last_in;
      scan_ff      <= scan_in;
      cmp_idx_ff   <= cmp_idx_in;
      res_hit_ff   <= res_hit_in;
      res_slot_ff  <= res_slot_in;
      res_evv_ff   <= res_evv_in;
      res_evp_ff   <= res_evp_in;
      res_fault_ff <= res_fault_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_FRAMES_IN_USE) ?
                       CSR_DATA_BITS'(fiu_ff) : '0;

   `CRP_ASSERT_NOW(a_hand_in_range, state == ST_OUT, CW'(hand_ff) < count,
                   "hand beyond active frames")
   `CRP_ASSERT_NEXT(a_evict_marks_slot, state == ST_EVICT,
                    valid_ff[res_slot_ff] && ref_ff[res_slot_ff],
                    "replaced frame not marked")
   `CRP_ASSERT_NEXT(a_fault_monotonic, 1'b1, fault_ff >= $past(fault_ff),
                    "fault count decreased")

endmodule
